// ===== hdl/kst_pkg.sv =====
// Shared types and codes for the keyed slot table.
`default_nettype none

package kst_pkg;

  localparam logic [1:0] REQ_ADD       = 2'd0;
  localparam logic [1:0] REQ_GET       = 2'd1;
  localparam logic [1:0] REQ_CLEAR     = 2'd2;
  localparam logic [1:0] REQ_CLEAR_ALL = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_KEY  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [31:0] FREE_KEY = 32'd0;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_WIPE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic ready;
    logic capture;
    logic scan;
    logic sweep;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_clear_all;
    logic in_zero_key;
    logic scan_end;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/kst_req_if.sv =====
// Request channel: valid/ready handshake with the request payload.
`default_nettype none

interface kst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] key;
  logic [31:0] data_in;

  modport source (output valid, output req_type, output key, output data_in, input ready);
  modport sink   (input valid, input req_type, input key, input data_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/kst_rsp_if.sv =====
// Response channel: valid/ready handshake with the result payload.
`default_nettype none

interface kst_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] data_out;
  logic [4:0]  live_count;

  modport source (output valid, output status, output data_out, output live_count, input ready);
  modport sink   (input valid, input status, input data_out, input live_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/keyed_slot_table.sv =====
// Top level: fixed-capacity key/data table with linear slot scan.
// Add, get, clear: slots are scanned in order until one decides or all miss, then the result
// is registered once the output is free; the next transfer is taken only back in idle.
// Zero key: result with no scan. Clear all: key sweep over every slot, then the result.
// The scan is set by the single read port of the key memory, one slot per cycle.
// After reset a clearing pass frees every slot; no request is taken meanwhile.
`default_nettype none

module keyed_slot_table import kst_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  kst_req_if.sink    req,
  kst_rsp_if.source  rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign req.ready = cmd.ready;

  kst_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  kst_dp #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (req.req_type),
    .in_key      (req.key),
    .in_data     (req.data_in),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_status  (rsp.status),
    .out_data    (rsp.data_out),
    .out_count   (rsp.live_count)
  );

endmodule

`default_nettype wire

// ===== hdl/kst_ctl.sv =====
// Controller state machine sequencing scan, sweep and result transfer.
`default_nettype none

module kst_ctl import kst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (stat.in_clear_all) begin
            state_next = S_WIPE;
          end else if (stat.in_zero_key) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_end) state_next = S_FINISH;
      end
      S_WIPE: begin
        if (stat.sweep_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_INIT:   cmd.sweep = 1'b1;
      S_IDLE: begin
        cmd.ready   = 1'b1;
        cmd.capture = in_valid;
      end
      S_SCAN:   cmd.scan = 1'b1;
      S_WIPE:   cmd.sweep = 1'b1;
      S_FINISH: cmd.finish = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/kst_dp.sv =====
// Datapath: slot memories, scan pointer, live count and result register.
`default_nettype none

module kst_dp import kst_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctl_cmd_t    cmd,
  output dp_stat_t         stat,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_data,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_data,
  output logic [4:0]       out_count
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [31:0]           keys [ENTRIES];
  logic [DATA_WIDTH-1:0] dmem [ENTRIES];

  logic [1:0]            req_q;
  logic [31:0]           key_q;
  logic [31:0]           data_q;
  logic [CNT_W-1:0]      ptr;
  logic [CNT_W-1:0]      live;
  logic [CNT_W-1:0]      live_next;

  logic [31:0]           rk_key;
  logic [DATA_WIDTH-1:0] rk_data;
  logic [IDX_W-1:0]      rk_idx;
  logic                  rk_vld;

  logic                  found;
  logic                  hit_free;
  logic [IDX_W-1:0]      hit_idx;
  logic [DATA_WIDTH-1:0] hit_data;

  logic                  issue;
  logic                  hit;
  logic [1:0]            st_next;
  logic [31:0]           dout_next;
  logic                  key_wr;
  logic [31:0]           key_wd;
  logic                  data_wr;
  logic                  kmem_we;
  logic [IDX_W-1:0]      kmem_wa;
  logic [31:0]           kmem_wd;
  logic [31:0]           live_ext;

  assign issue = cmd.scan && (ptr < CNT_W'(ENTRIES));
  assign hit   = rk_vld && ((rk_key == key_q) || ((req_q == REQ_ADD) && (rk_key == FREE_KEY)));

  assign stat.in_clear_all = (in_req_type == REQ_CLEAR_ALL);
  assign stat.in_zero_key  = (in_key == FREE_KEY);
  assign stat.scan_end     = hit || (rk_vld && (rk_idx == IDX_W'(ENTRIES - 1)));
  assign stat.sweep_last   = (ptr == CNT_W'(ENTRIES - 1));
  assign stat.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= in_req_type;
      key_q  <= in_key;
      data_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      rk_vld <= 1'b0;
    end else begin
      rk_vld <= issue;
      if (cmd.capture) begin
        ptr <= '0;
      end else if (issue || cmd.sweep) begin
        ptr <= ptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rk_vld) begin
      found    <= hit;
      hit_free <= (rk_key == FREE_KEY);
      hit_idx  <= rk_idx;
      hit_data <= rk_data;
    end
  end

  always_comb begin
    st_next   = ST_OK;
    dout_next = '0;
    live_next = live;
    key_wr    = 1'b0;
    key_wd    = key_q;
    data_wr   = 1'b0;
    if (req_q == REQ_CLEAR_ALL) begin
      live_next = '0;
    end else if (key_q == FREE_KEY) begin
      st_next = ST_ZERO_KEY;
    end else if (req_q == REQ_ADD) begin
      if (!found) begin
        st_next = ST_FULL;
      end else begin
        key_wr  = 1'b1;
        data_wr = 1'b1;
        if (hit_free) live_next = live + CNT_W'(1);
      end
    end else if (!found) begin
      st_next = ST_NOT_FOUND;
    end else if (req_q == REQ_GET) begin
      dout_next = 32'(hit_data);
    end else begin
      key_wr = 1'b1;
      key_wd = FREE_KEY;
      if (live != '0) live_next = live - CNT_W'(1);
    end
  end

  assign kmem_we  = cmd.sweep || (cmd.finish && key_wr);
  assign kmem_wa  = cmd.sweep ? ptr[IDX_W-1:0] : hit_idx;
  assign kmem_wd  = cmd.sweep ? FREE_KEY : key_wd;
  assign live_ext = 32'(live_next);

  always_ff @(posedge clk) begin
    if (kmem_we) keys[kmem_wa] <= kmem_wd;
    rk_key <= keys[ptr[IDX_W-1:0]];
    rk_idx <= ptr[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && data_wr) dmem[hit_idx] <= DATA_WIDTH'(data_q);
    rk_data <= dmem[ptr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish || (out_valid && !out_ready);
      if (cmd.finish) live <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= st_next;
      out_data   <= dout_next;
      out_count  <= (live_ext > 32'd31) ? 5'd31 : live_ext[4:0];
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_W'(ENTRIES))
    else $error("live count above capacity");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");

  a_clear_all_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && (req_q == REQ_CLEAR_ALL)) |=> (out_count == 5'd0 && live == '0))
    else $error("clear all left live entries");

endmodule

`default_nettype wire
